>>> rtl/polyline_arc_length_point_defines.svh
// assertion macros shared by the polyline arc length block
// no dependencies
`ifndef POLYLINE_ARC_LENGTH_POINT_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_POINT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PAL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pal_pkg.sv
// types and constants for the polyline arc length block
// no dependencies
package pal_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned RegIdxW = 2;

    localparam logic [RegIdxW-1:0] RegTarget = 2'd0;
    localparam logic [RegIdxW-1:0] RegSrcX = 2'd1;
    localparam logic [RegIdxW-1:0] RegSrcY = 2'd2;
    localparam logic [RegIdxW-1:0] RegSrcZ = 2'd3;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
    } vec3_t;

    // one classified word for the back end
    typedef struct packed {
        vec3_t point;
        logic  ray_end;
        logic  empty_ray;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_ADD,
        ST_DECIDE,
        ST_DIV,
        ST_MUL,
        ST_LERP,
        ST_OUT
    } state_t;

endpackage

>>> rtl/pal_front.sv
// input side: takes words and holds them in a two-entry queue
// depends on pal_pkg
module pal_front
    import pal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  item_t        in_item,
    output logic         q_valid,
    input  logic         q_pop,
    output item_t        q_item
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

>>> rtl/pal_back.sv
// back end: segment length by bitwise square root, crossing ratio by
// restoring division, then interpolation; depends on pal_pkg
module pal_back
    import pal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_pop,
    input  item_t        q_item,
    input  logic [31:0]  target,
    input  vec3_t        source,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  out_len,
    output logic         out_wave_valid,
    output vec3_t        out_wave
);

    state_t        state_reg, state_next;
    item_t         item_reg;
    vec3_t         prev_reg;
    logic [31:0]   run_reg;
    logic          found_reg;
    logic          started_reg;
    vec3_t         wave_reg;
    logic [31:0]   newlen_reg;
    logic [1:0]    ax_reg;
    logic [65:0]   sum_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   res_reg;
    logic [5:0]    cnt_reg;
    logic [31:0]   seg_reg;
    logic          take_far_reg;
    logic          take_near_reg;
    logic [32:0]   dnum_reg;
    logic [31:0]   den_reg;
    logic [31:0]   ratio_reg;
    logic [63:0]   prod_reg;

    logic [32:0]   diff;
    logic [31:0]   mag;
    logic [31:0]   pa, pb;
    logic [63:0]   sq;
    logic [5:0]    cnt_m1;
    logic [63:0]   sq_bit;
    logic [63:0]   trial;
    logic [32:0]   sumlen;
    logic [33:0]   dsh;
    logic [31:0]   off;
    logic [32:0]   lerp_res;
    logic [31:0]   near_c, far_c;
    logic          is_neg;

    always_comb
    begin
        case (ax_reg)
            2'd0:    begin pa = prev_reg.x; pb = item_reg.point.x; end
            2'd1:    begin pa = prev_reg.y; pb = item_reg.point.y; end
            default: begin pa = prev_reg.z; pb = item_reg.point.z; end
        endcase
    end

    assign diff   = {pb[31], pb} - {pa[31], pa};
    assign is_neg = diff[32];
    assign mag    = is_neg ? 32'(-diff) : diff[31:0];
    assign sq     = 64'(mag) * 64'(mag);
    assign near_c = pa;
    assign far_c  = pb;
    // sqrt step: bit position 2*(cnt-1), from 62 down to 0
    assign cnt_m1 = cnt_reg - 6'd1;
    assign sq_bit = 64'd1 << {cnt_m1[4:0], 1'b0};
    assign trial  = res_reg + sq_bit;
    assign sumlen = {1'b0, run_reg} + {1'b0, seg_reg};
    assign dsh    = {dnum_reg, 1'b0};
    assign off    = prod_reg[63:32];
    assign lerp_res = is_neg ? ({near_c[31], near_c} - {1'b0, off})
                             : ({near_c[31], near_c} + {1'b0, off});

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_SQ;
            ST_SQ:     if (item_reg.empty_ray) state_next = ST_OUT;
                       else if (ax_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == 6'd0 || sum_reg[65:64] != 2'd0)
                           state_next = ST_ADD;
            ST_ADD:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_DIV;
            ST_DIV:    if (take_far_reg || take_near_reg || cnt_reg == 6'd0)
                           state_next = ST_MUL;
            ST_MUL:    state_next = ST_LERP;
            ST_LERP:   if (ax_reg == 2'd2) state_next = ST_OUT;
                       else state_next = ST_MUL;
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            prev_reg    <= '0;
            run_reg     <= '0;
            found_reg   <= 1'b0;
            started_reg <= 1'b0;
            wave_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                if (q_valid)
                begin
                    item_reg <= q_item;
                    ax_reg   <= 2'd0;
                    sum_reg  <= '0;
                    if (!started_reg && !q_item.empty_ray)
                    begin
                        prev_reg  <= source;
                        run_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                end
                ST_SQ:
                begin
                    sum_reg <= sum_reg + {2'b0, sq};
                    rem_reg <= sum_reg[63:0] + sq;
                    ax_reg  <= ax_reg + 2'd1;
                    res_reg <= '0;
                    cnt_reg <= 6'd32;
                    if (item_reg.empty_ray)
                    begin
                        started_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        run_reg     <= '0;
                        newlen_reg  <= '0;
                    end
                end
                ST_SQRT:
                begin
                    if (sum_reg[65:64] != 2'd0)
                    begin
                        seg_reg <= 32'hFFFF_FFFF;
                    end
                    else if (cnt_reg != 6'd0)
                    begin
                        // one result bit a cycle, 32 in all
                        if (rem_reg >= trial)
                        begin
                            rem_reg <= rem_reg - trial;
                            res_reg <= (res_reg >> 1) + sq_bit;
                        end
                        else
                        begin
                            res_reg <= res_reg >> 1;
                        end
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                    else
                    begin
                        seg_reg <= res_reg[31:0];
                    end
                end
                ST_ADD:
                    newlen_reg <= sumlen[32] ? 32'hFFFF_FFFF : sumlen[31:0];
                ST_DECIDE:
                begin
                    dnum_reg      <= {1'b0, target - run_reg};
                    den_reg       <= newlen_reg - run_reg;
                    ratio_reg     <= '0;
                    cnt_reg       <= 6'd32;
                    ax_reg        <= 2'd0;
                    if (found_reg || !(newlen_reg >= target || item_reg.ray_end))
                    begin
                        take_far_reg  <= 1'b0;
                        take_near_reg <= 1'b1;
                    end
                    else if (newlen_reg <= run_reg)
                    begin
                        take_far_reg  <= 1'b1;
                        take_near_reg <= 1'b0;
                    end
                    else if (target <= run_reg)
                    begin
                        take_far_reg  <= 1'b0;
                        take_near_reg <= 1'b1;
                    end
                    else if (target >= newlen_reg)
                    begin
                        take_far_reg  <= 1'b1;
                        take_near_reg <= 1'b0;
                    end
                    else
                    begin
                        take_far_reg  <= 1'b0;
                        take_near_reg <= 1'b0;
                    end
                end
                ST_DIV:
                if (!take_far_reg && !take_near_reg && cnt_reg != 6'd0)
                begin
                    if (dsh >= {2'b0, den_reg})
                    begin
                        dnum_reg  <= 33'(dsh - {2'b0, den_reg});
                        ratio_reg <= {ratio_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        dnum_reg  <= dsh[32:0];
                        ratio_reg <= {ratio_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                end
                ST_MUL:
                    prod_reg <= 64'(mag) * 64'(ratio_reg);
                ST_LERP:
                begin
                    ax_reg <= ax_reg + 2'd1;
                    // latch only on the crossing segment, or on the ray's last segment if none was found
                    if (!found_reg && (newlen_reg >= target || item_reg.ray_end))
                    begin
                        case (ax_reg)
                            2'd0: wave_reg.x <= take_far_reg ? far_c :
                                  take_near_reg ? near_c : lerp_res[31:0];
                            2'd1: wave_reg.y <= take_far_reg ? far_c :
                                  take_near_reg ? near_c : lerp_res[31:0];
                            default: wave_reg.z <= take_far_reg ? far_c :
                                  take_near_reg ? near_c : lerp_res[31:0];
                        endcase
                    end
                    if (ax_reg == 2'd2)
                    begin
                        if (newlen_reg >= target || item_reg.ray_end)
                            found_reg <= 1'b1;
                        prev_reg <= item_reg.point;
                        if (item_reg.ray_end)
                        begin
                            started_reg <= 1'b0;
                            run_reg     <= '0;
                        end
                        else
                        begin
                            started_reg <= 1'b1;
                            run_reg     <= newlen_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_len        = newlen_reg;
    assign out_wave_valid = item_reg.empty_ray || item_reg.ray_end;
    assign out_wave       = item_reg.empty_ray ? source :
                            (item_reg.ray_end ? wave_reg : '0);

endmodule

>>> rtl/polyline_arc_length_point.sv
// top level of the polyline arc length block: front queue, back end, registers
// depends on pal_pkg, pal_front, pal_back and the defines header
//
// channel  direction  contents
// s_axis   in         tdata: point_x, point_y, point_z; tlast: ray_end; tuser: empty_ray
// m_axis   out        tdata: path_length, wave_x, wave_y, wave_z; tuser: wave_valid
// cfg      in         write enable, index, 32-bit data
//
// a point passes the back end through squaring per axis, square root, add, decide,
// multiply and interpolate per axis, and output; the divider runs only if the crossing
// needs it, root steps are skipped if the squared length overflows; an empty ray goes
// from squaring to output; rst_n clears state and registers at once; the two-word queue
// holds the word in work and takes one more while the back end waits on m_axis_tready
`include "polyline_arc_length_point_defines.svh"
module polyline_arc_length_point
    import pal_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,   // point_x, point_y, point_z
    input  logic          s_axis_tlast,   // ray_end
    input  logic          s_axis_tuser,   // empty_ray
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // path_length, wave_x, wave_y, wave_z
    output logic          m_axis_tuser,   // wave_valid
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    logic [31:0] target_reg;
    vec3_t       source_reg;
    item_t       in_item, q_item;
    logic        q_valid, q_pop;
    logic [31:0] out_len;
    vec3_t       out_wave;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            source_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegTarget: target_reg   <= cfg_data;
                RegSrcX:   source_reg.x <= cfg_data;
                RegSrcY:   source_reg.y <= cfg_data;
                RegSrcZ:   source_reg.z <= cfg_data;
                default:   target_reg   <= target_reg;
            endcase
        end
    end

    assign in_item.point.x   = s_axis_tdata[31:0];
    assign in_item.point.y   = s_axis_tdata[63:32];
    assign in_item.point.z   = s_axis_tdata[95:64];
    assign in_item.ray_end   = s_axis_tlast;
    assign in_item.empty_ray = s_axis_tuser;

    pal_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    pal_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .target         (target_reg),
        .source         (source_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_len        (out_len),
        .out_wave_valid (m_axis_tuser),
        .out_wave       (out_wave)
    );

    assign m_axis_tdata = {out_wave.z, out_wave.y, out_wave.x, out_len};

    `PAL_ASSERT_IMP(a_pop_needs_word, q_pop, q_valid, "pop from empty queue")
    `PAL_ASSERT_IMP(a_pop_on_output, q_pop, m_axis_tvalid && m_axis_tready, "pop without output")
    `PAL_ASSERT_NEXT(a_out_then_idle, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "output held")

endmodule
